@@ src/ll1asc_pkg.sv @@
// Shared constants, types and character classes of the assignment syntax checker.
package ll1asc_pkg;

   localparam int DEFAULT_STACK_DEPTH = 64;

   localparam logic [1:0] VERDICT_PENDING = 2'd0;
   localparam logic [1:0] VERDICT_VALID   = 2'd1;
   localparam logic [1:0] VERDICT_INVALID = 2'd2;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_END    = 8'h24;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2a;
   localparam logic [7:0] CH_PLUS   = 8'h2b;
   localparam logic [7:0] CH_MINUS  = 8'h2d;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_SEMI   = 8'h3b;
   localparam logic [7:0] CH_EQ     = 8'h3d;

   localparam logic [7:0] NT_ASSIGN = 8'h80;
   localparam logic [7:0] NT_IDENT  = 8'h81;
   localparam logic [7:0] NT_IDTAIL = 8'h82;
   localparam logic [7:0] NT_EXP    = 8'h83;
   localparam logic [7:0] NT_EXPT   = 8'h84;
   localparam logic [7:0] NT_TERM   = 8'h85;
   localparam logic [7:0] NT_TERMT  = 8'h86;
   localparam logic [7:0] NT_FACT   = 8'h87;
   localparam logic [7:0] NT_LIT    = 8'h88;
   localparam logic [7:0] NT_DIGITS = 8'h89;

   typedef struct packed {
      logic            done;
      logic [1:0]      verdict;
      logic            pop;
      logic [2:0]      cnt;
      logic [3:0][7:0] syms;
      logic            cont;
   } action_type;

   function automatic logic is_letter(input logic [7:0] c);
      return c inside {[8'h61:8'h7a], [8'h41:8'h5a], 8'h5f};
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[CH_ZERO:CH_NINE]};
   endfunction

   function automatic logic is_delim(input logic [7:0] c);
      return c inside {CH_EQ, CH_END, CH_PLUS, CH_MINUS, CH_STAR, CH_SEMI, CH_LPAREN,
                       CH_RPAREN};
   endfunction

   function automatic logic starts_term(input logic [7:0] c);
      return is_digit(c) || is_letter(c) || (c inside {CH_LPAREN, CH_PLUS, CH_MINUS});
   endfunction

endpackage

@@ src/ll1_assignment_syntax_checker.sv @@
// Top level of the table-driven syntax checker for one assignment statement.
// Each request transaction carries one character of a statement; '$' ends it.
// Each character yields exactly one response transaction whose verdict is
// pending (character accepted so far), valid or invalid. After a valid or
// invalid verdict the symbol stack restarts for the next statement.
// A character takes one read of the stack memory plus one table lookup per
// expansion step, and one push step per symbol pushed, all done by one
// sequencer over a single-port stack memory. The response is registered
// after the READ and EVAL states at the earliest, and a character inside a
// name or a number passes only through IDLE, READ and EVAL before the next
// one is taken. The longest chain is an operand that opens an expression,
// which expands Exp, Term, Fact and then the literal or name in turn.
// req_ready is high only while the sequencer is idle; a new character is
// taken while an earlier response still waits on rsp_ready. If the response
// register is still full when a verdict is ready, the sequencer holds it
// until the receiver takes the earlier one.
// After reset the block places the start symbol on the stack in its INIT
// state before it raises req_ready.
module ll1_assignment_syntax_checker
   import ll1asc_pkg::*;
#(
   parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_verdict
);

   localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   localparam logic [2:0] ST_INIT = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_READ = 3'd2;
   localparam logic [2:0] ST_EVAL = 3'd3;
   localparam logic [2:0] ST_PUSH = 3'd4;
   localparam logic [2:0] ST_HOLD = 3'd5;

   logic [7:0] stack_mem [STACK_DEPTH];

   logic [2:0]       state_ff, state_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic [7:0]       char_ff, char_in;
   logic [3:0][7:0]  syms_ff, syms_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic [1:0]       idx_ff, idx_in;
   logic             cont_ff, cont_in;
   logic             replace_ff, replace_in;
   logic             bottom_ff, bottom_in;
   logic [1:0]       hold_ff, hold_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_verdict_ff, rsp_verdict_in;
   logic [7:0]       rdata_ff;

   logic              we;
   logic [ADDR_W-1:0] waddr;
   logic [7:0]        wdata;
   logic [ADDR_W-1:0] raddr;
   logic [7:0]        top;
   action_type        act;
   logic              finish;
   logic [1:0]        fin_verdict;
   logic              out_free;
   logic [7:0]        push_sym;
   logic              push_last;

   assign top = bottom_ff ? CH_END : rdata_ff;

   ll1asc_table u_table (
      .top (top),
      .ch  (char_ff),
      .act (act)
   );

   assign raddr     = ADDR_W'(level_ff - LVL_W'(1));
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign push_sym  = syms_ff[idx_ff];
   assign push_last = (({1'b0, idx_ff} + 3'd1) == cnt_ff);

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = rsp_verdict_ff;

   always_comb begin
      state_in       = state_ff;
      level_in       = level_ff;
      char_in        = char_ff;
      syms_in        = syms_ff;
      cnt_in         = cnt_ff;
      idx_in         = idx_ff;
      cont_in        = cont_ff;
      replace_in     = replace_ff;
      bottom_in      = bottom_ff;
      hold_in        = hold_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_verdict_in = rsp_verdict_ff;
      we             = 1'b0;
      waddr          = raddr;
      wdata          = push_sym;
      finish         = 1'b0;
      fin_verdict    = VERDICT_PENDING;

      case (state_ff)
         ST_INIT: begin
            we       = 1'b1;
            waddr    = ADDR_W'(1);
            wdata    = NT_ASSIGN;
            level_in = LVL_W'(2);
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               char_in  = req_char_code;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            bottom_in = (level_ff == LVL_W'(1));
            state_in  = ST_EVAL;
         end
         ST_EVAL: begin
            if (act.done) begin
               finish      = 1'b1;
               fin_verdict = act.verdict;
            end else if (act.cnt == 3'd0) begin
               if (act.pop) begin
                  level_in = level_ff - LVL_W'(1);
               end
               if (act.cont) begin
                  state_in = ST_READ;
               end else begin
                  finish = 1'b1;
               end
            end else begin
               syms_in    = act.syms;
               cnt_in     = act.cnt;
               idx_in     = 2'd0;
               cont_in    = act.cont;
               replace_in = act.pop;
               state_in   = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (idx_ff == 2'd0 && replace_ff) begin
               we = 1'b1;
            end else if (level_ff == LVL_W'(STACK_DEPTH)) begin
               finish      = 1'b1;
               fin_verdict = VERDICT_INVALID;
            end else begin
               we       = 1'b1;
               waddr    = ADDR_W'(level_ff);
               level_in = level_ff + LVL_W'(1);
            end
            if (!finish) begin
               idx_in = idx_ff + 2'd1;
               if (push_last) begin
                  if (cont_ff) begin
                     state_in = ST_READ;
                  end else begin
                     finish = 1'b1;
                  end
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = hold_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase

      if (finish) begin
         if (fin_verdict != VERDICT_PENDING) begin
            level_in = LVL_W'(2);
            we       = 1'b1;
            waddr    = ADDR_W'(1);
            wdata    = NT_ASSIGN;
         end
         if (out_free) begin
            rsp_valid_in   = 1'b1;
            rsp_verdict_in = fin_verdict;
            state_in       = ST_IDLE;
         end else begin
            hold_in  = fin_verdict;
            state_in = ST_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         stack_mem[waddr] <= wdata;
      end
      if (state_ff == ST_READ) begin
         rdata_ff <= stack_mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         level_ff     <= LVL_W'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff        <= char_in;
      syms_ff        <= syms_in;
      cnt_ff         <= cnt_in;
      idx_ff         <= idx_in;
      cont_ff        <= cont_in;
      replace_ff     <= replace_in;
      bottom_ff      <= bottom_in;
      hold_ff        <= hold_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff != LVL_W'(0) && level_ff <= LVL_W'(STACK_DEPTH))
      else $error("stack level out of range");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      finish && fin_verdict != VERDICT_PENDING |=> level_ff == LVL_W'(2))
      else $error("stack did not restart after a verdict");

   a_hold_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HOLD |-> rsp_valid_ff)
      else $error("verdict held while response register is empty");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !(state_ff == ST_IDLE))
      else $error("transaction accepted without work");

endmodule

@@ src/ll1asc_table.sv @@
// Parse table: the stack edit or verdict for one top symbol and one character.
module ll1asc_table
   import ll1asc_pkg::*;
(
   input  logic [7:0] top,
   input  logic [7:0] ch,
   output action_type act
);

   always_comb begin
      act = '0;
      case (top)
         NT_ASSIGN: begin
            if (!is_letter(ch)) begin
               act.done = 1'b1;
               act.verdict = VERDICT_INVALID;
            end else begin
               act.pop = 1'b1;
               act.cnt = 3'd4;
               act.syms[0] = CH_SEMI;
               act.syms[1] = NT_EXP;
               act.syms[2] = CH_EQ;
               act.syms[3] = NT_IDENT;
               act.cont = 1'b1;
            end
         end
         NT_IDENT: begin
            if (!is_letter(ch)) begin
               act.done = 1'b1;
               act.verdict = VERDICT_INVALID;
            end else begin
               act.pop = 1'b1;
               act.cnt = 3'd1;
               act.syms[0] = NT_IDTAIL;
            end
         end
         NT_IDTAIL: begin
            if (is_delim(ch)) begin
               act.pop = 1'b1;
               act.cont = 1'b1;
            end
         end
         NT_DIGITS: begin
            if (!is_digit(ch)) begin
               act.pop = 1'b1;
               act.cont = 1'b1;
            end
         end
         NT_EXP, NT_TERM: begin
            if (!starts_term(ch)) begin
               act.done = 1'b1;
               act.verdict = VERDICT_INVALID;
            end else begin
               act.pop = 1'b1;
               act.cnt = 3'd2;
               act.syms[0] = (top == NT_EXP) ? NT_EXPT : NT_TERMT;
               act.syms[1] = (top == NT_EXP) ? NT_TERM : NT_FACT;
               act.cont = 1'b1;
            end
         end
         NT_EXPT: begin
            if (ch inside {CH_PLUS, CH_MINUS}) begin
               act.cnt = 3'd1;
               act.syms[0] = NT_TERM;
            end else if (ch inside {CH_SEMI, CH_NUL, CH_RPAREN, CH_END}) begin
               act.pop = 1'b1;
               act.cont = 1'b1;
            end else begin
               act.done = 1'b1;
               act.verdict = VERDICT_INVALID;
            end
         end
         NT_TERMT: begin
            if (ch == CH_STAR) begin
               act.cnt = 3'd1;
               act.syms[0] = NT_FACT;
            end else if (ch inside {CH_RPAREN, CH_PLUS, CH_MINUS, CH_SEMI, CH_NUL, CH_END})
            begin
               act.pop = 1'b1;
               act.cont = 1'b1;
            end else begin
               act.done = 1'b1;
               act.verdict = VERDICT_INVALID;
            end
         end
         NT_FACT: begin
            if (is_digit(ch)) begin
               act.pop = 1'b1;
               act.cnt = 3'd1;
               act.syms[0] = NT_LIT;
               act.cont = 1'b1;
            end else if (is_letter(ch)) begin
               act.pop = 1'b1;
               act.cnt = 3'd1;
               act.syms[0] = NT_IDENT;
               act.cont = 1'b1;
            end else if (ch == CH_LPAREN) begin
               act.pop = 1'b1;
               act.cnt = 3'd2;
               act.syms[0] = CH_RPAREN;
               act.syms[1] = NT_EXP;
            end else if (!(ch inside {CH_PLUS, CH_MINUS})) begin
               act.done = 1'b1;
               act.verdict = VERDICT_INVALID;
            end
         end
         NT_LIT: begin
            if (ch == CH_ZERO) begin
               act.pop = 1'b1;
            end else if (is_digit(ch)) begin
               act.pop = 1'b1;
               act.cnt = 3'd1;
               act.syms[0] = NT_DIGITS;
            end else begin
               act.done = 1'b1;
               act.verdict = VERDICT_INVALID;
            end
         end
         default: begin
            if (top[7] || top != ch) begin
               act.done = 1'b1;
               act.verdict = VERDICT_INVALID;
            end else if (top == CH_END) begin
               act.done = 1'b1;
               act.verdict = VERDICT_VALID;
            end else begin
               act.pop = 1'b1;
            end
         end
      endcase
   end

endmodule

@@ tb/sv/ll1_assignment_syntax_checker_tb.sv @@
// Self-checking testbench of the assignment syntax checker: directed table, random statements.
module ll1_assignment_syntax_checker_tb;
   import ll1asc_pkg::*;

   localparam int DEPTH = DEFAULT_STACK_DEPTH;
   localparam int RANDOM_CHARS = 600;
   localparam int CALM_AFTER = 480;

   typedef struct packed {
      logic [7:0] ch;
      logic       fixed;
      logic [1:0] verdict;
   } stim_row_type;

   localparam int DIR_ROWS = 23;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_char_code;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [1:0] rsp_verdict;

   logic       row_fixed;
   logic [1:0] row_verdict;
   bit         calm;
   int         chars_sent;
   int         err_count;
   logic [1:0] verdict_q[$];
   logic [7:0] stmt_q[$];

   logic [7:0] sym_stack[DEPTH];
   int         sym_level;

   stim_row_type dir_table[DIR_ROWS] = '{
      '{CH_NUL,    1'b1, VERDICT_INVALID},
      '{CH_END,    1'b1, VERDICT_INVALID},
      '{"a",       1'b0, VERDICT_PENDING},
      '{8'hff,     1'b0, VERDICT_PENDING},
      '{CH_EQ,     1'b0, VERDICT_PENDING},
      '{CH_ZERO,   1'b0, VERDICT_PENDING},
      '{CH_END,    1'b0, VERDICT_PENDING},
      '{"b",       1'b0, VERDICT_PENDING},
      '{CH_EQ,     1'b0, VERDICT_PENDING},
      '{CH_LPAREN, 1'b0, VERDICT_PENDING},
      '{CH_MINUS,  1'b0, VERDICT_PENDING},
      '{"7",       1'b0, VERDICT_PENDING},
      '{CH_STAR,   1'b0, VERDICT_PENDING},
      '{"c",       1'b0, VERDICT_PENDING},
      '{CH_RPAREN, 1'b0, VERDICT_PENDING},
      '{CH_PLUS,   1'b0, VERDICT_PENDING},
      '{CH_ZERO,   1'b0, VERDICT_PENDING},
      '{CH_NUL,    1'b0, VERDICT_PENDING},
      '{"z",       1'b0, VERDICT_PENDING},
      '{CH_EQ,     1'b0, VERDICT_PENDING},
      '{"1",       1'b0, VERDICT_PENDING},
      '{CH_SEMI,   1'b0, VERDICT_PENDING},
      '{CH_END,    1'b1, VERDICT_VALID}
   };

   ll1_assignment_syntax_checker #(
      .STACK_DEPTH(DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_char_code(req_char_code),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_verdict(rsp_verdict)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic bit alpha_ch(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic bit digit_ch(input logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic bit delim_ch(input logic [7:0] c);
      return c == CH_EQ || c == CH_END || c == CH_PLUS || c == CH_MINUS ||
             c == CH_STAR || c == CH_SEMI || c == CH_LPAREN || c == CH_RPAREN;
   endfunction

   function automatic void stack_restart();
      foreach (sym_stack[k]) sym_stack[k] = 8'h00;
      sym_stack[0] = CH_END;
      sym_stack[1] = NT_ASSIGN;
      sym_level = 2;
   endfunction

   function automatic bit stack_push(input logic [7:0] s);
      if (sym_level >= DEPTH) return 1'b0;
      sym_stack[sym_level] = s;
      sym_level++;
      return 1'b1;
   endfunction

   function automatic void stack_pop();
      if (sym_level > 0) sym_level--;
   endfunction

   function automatic logic [1:0] advance_parser(input logic [7:0] c);
      logic [7:0] top;
      forever begin
         if (sym_level == 0 || sym_level > DEPTH) return VERDICT_INVALID;
         top = sym_stack[sym_level - 1];
         if (top < 8'h80) begin
            if (top != c) return VERDICT_INVALID;
            if (top == CH_END) return VERDICT_VALID;
            stack_pop();
            return VERDICT_PENDING;
         end
         case (top)
            NT_ASSIGN: begin
               if (!alpha_ch(c)) return VERDICT_INVALID;
               stack_pop();
               if (!(stack_push(CH_SEMI) && stack_push(NT_EXP) && stack_push(CH_EQ) &&
                     stack_push(NT_IDENT))) return VERDICT_INVALID;
            end
            NT_IDENT: begin
               if (!alpha_ch(c)) return VERDICT_INVALID;
               stack_pop();
               if (!stack_push(NT_IDTAIL)) return VERDICT_INVALID;
               return VERDICT_PENDING;
            end
            NT_IDTAIL: begin
               if (!delim_ch(c)) return VERDICT_PENDING;
               stack_pop();
            end
            NT_DIGITS: begin
               if (digit_ch(c)) return VERDICT_PENDING;
               stack_pop();
            end
            NT_EXP, NT_TERM: begin
               if (!(digit_ch(c) || alpha_ch(c) || c == CH_LPAREN || c == CH_PLUS ||
                     c == CH_MINUS)) return VERDICT_INVALID;
               stack_pop();
               if (top == NT_EXP) begin
                  if (!(stack_push(NT_EXPT) && stack_push(NT_TERM))) return VERDICT_INVALID;
               end else begin
                  if (!(stack_push(NT_TERMT) && stack_push(NT_FACT))) return VERDICT_INVALID;
               end
            end
            NT_EXPT: begin
               if (c == CH_PLUS || c == CH_MINUS) begin
                  if (!stack_push(NT_TERM)) return VERDICT_INVALID;
                  return VERDICT_PENDING;
               end
               if (!(c == CH_SEMI || c == CH_NUL || c == CH_RPAREN || c == CH_END))
                  return VERDICT_INVALID;
               stack_pop();
            end
            NT_TERMT: begin
               if (c == CH_STAR) begin
                  if (!stack_push(NT_FACT)) return VERDICT_INVALID;
                  return VERDICT_PENDING;
               end
               if (!(c == CH_RPAREN || c == CH_PLUS || c == CH_MINUS || c == CH_SEMI ||
                     c == CH_NUL || c == CH_END)) return VERDICT_INVALID;
               stack_pop();
            end
            NT_FACT: begin
               if (digit_ch(c)) begin
                  stack_pop();
                  if (!stack_push(NT_LIT)) return VERDICT_INVALID;
               end else if (alpha_ch(c)) begin
                  stack_pop();
                  if (!stack_push(NT_IDENT)) return VERDICT_INVALID;
               end else if (c == CH_LPAREN) begin
                  stack_pop();
                  if (!(stack_push(CH_RPAREN) && stack_push(NT_EXP))) return VERDICT_INVALID;
                  return VERDICT_PENDING;
               end else if (c == CH_PLUS || c == CH_MINUS) begin
                  return VERDICT_PENDING;
               end else begin
                  return VERDICT_INVALID;
               end
            end
            NT_LIT: begin
               if (c == CH_ZERO) begin
                  stack_pop();
                  return VERDICT_PENDING;
               end
               if (!digit_ch(c)) return VERDICT_INVALID;
               stack_pop();
               if (!stack_push(NT_DIGITS)) return VERDICT_INVALID;
               return VERDICT_PENDING;
            end
            default: return VERDICT_INVALID;
         endcase
      end
      return VERDICT_INVALID;
   endfunction

   function automatic logic [1:0] predict_verdict(input logic [7:0] c);
      logic [1:0] v;
      v = advance_parser(c);
      if (v != VERDICT_PENDING) stack_restart();
      return v;
   endfunction

   function automatic logic [7:0] pick_letter();
      int r;
      r = $urandom_range(0, 52);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      return "_";
   endfunction

   function automatic logic [7:0] pick_tail();
      logic [7:0] c;
      if ($urandom_range(0, 7) != 0) begin
         if ($urandom_range(0, 2) == 0) return 8'(CH_ZERO + $urandom_range(0, 9));
         return pick_letter();
      end
      c = 8'($urandom_range(0, 255));
      while (delim_ch(c)) c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   function automatic void emit_ident();
      int n;
      n = $urandom_range(0, 4);
      stmt_q.push_back(pick_letter());
      repeat (n) stmt_q.push_back(pick_tail());
   endfunction

   function automatic void emit_literal();
      int n;
      n = $urandom_range(0, 3);
      if ($urandom_range(0, 2) == 0) begin
         stmt_q.push_back(CH_ZERO);
      end else begin
         stmt_q.push_back(8'(CH_ZERO + $urandom_range(1, 9)));
         repeat (n) stmt_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      end
   endfunction

   function automatic void emit_fact(input int depth);
      int r;
      r = $urandom_range(0, 9);
      if (r <= 3 || (r <= 8 && r >= 7 && depth == 0)) begin
         emit_literal();
      end else if (r <= 6) begin
         emit_ident();
      end else if (r <= 8) begin
         stmt_q.push_back(CH_LPAREN);
         emit_expr(depth - 1);
         stmt_q.push_back(CH_RPAREN);
      end else begin
         stmt_q.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
         emit_fact(depth);
      end
   endfunction

   function automatic void emit_term(input int depth);
      int n;
      n = $urandom_range(0, 2);
      emit_fact(depth);
      repeat (n) begin
         stmt_q.push_back(CH_STAR);
         emit_fact(depth);
      end
   endfunction

   function automatic void emit_expr(input int depth);
      int n;
      n = $urandom_range(0, 2);
      emit_term(depth);
      repeat (n) begin
         stmt_q.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
         emit_term(depth);
      end
   endfunction

   function automatic void build_statement();
      int n;
      int m;
      stmt_q.delete();
      emit_ident();
      stmt_q.push_back(CH_EQ);
      if ($urandom_range(0, 19) == 0) begin
         n = $urandom_range(16, 24);
         repeat (n) stmt_q.push_back(CH_LPAREN);
         emit_ident();
         repeat (n) stmt_q.push_back(CH_RPAREN);
      end else begin
         emit_expr(2);
      end
      stmt_q.push_back(CH_SEMI);
      stmt_q.push_back(CH_END);
      m = $urandom_range(0, 9);
      if (m == 0) begin
         stmt_q[$urandom_range(0, stmt_q.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (m == 1) begin
         n = $urandom_range(1, stmt_q.size() - 1);
         while (stmt_q.size() > n) void'(stmt_q.pop_back());
         stmt_q.push_back(CH_END);
      end else if (m == 2) begin
         stmt_q.delete();
         stmt_q.push_back(8'($urandom_range(0, 255)));
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [1:0] got,
                                  input logic [1:0] want);
      $display("mismatch at %0t: %s, verdict %0d, expected %0d", $time, what, got, want);
      err_count++;
   endtask

   task automatic send_char(input logic [7:0] c, input logic fixed, input logic [1:0] v);
      int gap;
      @(negedge clock);
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_char_code = c;
      row_fixed = fixed;
      row_verdict = v;
      do @(posedge clock); while (req_ready !== 1'b1);
      chars_sent++;
      calm = (chars_sent >= DIR_ROWS + CALM_AFTER);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      logic [1:0] want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            want = predict_verdict(req_char_code);
            if (row_fixed) want = row_verdict;
            verdict_q.push_back(want);
         end
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               report_mismatch("response with no transaction pending", rsp_verdict, 2'd0);
            end else begin
               want = verdict_q.pop_front();
               if (rsp_verdict !== want) report_mismatch("wrong verdict", rsp_verdict, want);
            end
         end
      end
   end

   initial begin
      int n;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 5);
            rsp_ready = 1'b0;
            repeat (n) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
            @(negedge clock);
         end
      end
   end

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   initial begin
      bit paused;
      reset = 1'b1;
      req_valid = 1'b0;
      req_char_code = 8'h00;
      row_fixed = 1'b0;
      row_verdict = VERDICT_PENDING;
      calm = 1'b0;
      chars_sent = 0;
      err_count = 0;
      paused = 1'b0;
      stack_restart();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_table[i]) send_char(dir_table[i].ch, dir_table[i].fixed,
                                       dir_table[i].verdict);
      drain_results();

      while (chars_sent < DIR_ROWS + RANDOM_CHARS) begin
         build_statement();
         foreach (stmt_q[i]) send_char(stmt_q[i], 1'b0, VERDICT_PENDING);
         if (!paused && chars_sent >= DIR_ROWS + RANDOM_CHARS / 2) begin
            drain_results();
            paused = 1'b1;
         end
      end

      drain_results();
      repeat (30) @(posedge clock);
      if (err_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
